/* hw/rtl/vzz_pkg.sv */
// Package: shared constants and types for the varint/zigzag codec.
`default_nettype none
package vzz_pkg;

  // Opcodes of an input transaction
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // Kinds of a result transaction
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  // Byte format
  localparam logic [7:0] CONT_BIT     = 8'h80;
  localparam logic [6:0] PAYLOAD_MASK = 7'h7F;
  localparam int unsigned PAYLOAD_BITS = 7;

  // Maximum run length per form
  localparam logic [3:0] NARROW_MAX_BYTES = 4'd5;
  localparam logic [3:0] WIDE_MAX_BYTES   = 4'd10;

  // Default depth of the queue between front and back end (at least 2)
  localparam int unsigned QUEUE_DEPTH = 4;

  // Job handed from the front end to the back end
  typedef struct packed {
    logic        kind;       // KIND_BYTE: serialize value, KIND_VALUE: emit value
    logic        is_signed;  // zigzag-decode on emit (value jobs)
    logic        is_wide;    // 64-bit form (value jobs)
    logic [63:0] value;      // mapped value to encode, or raw accumulated value
  } vzz_job_t;

  // Queue status seen by the front end
  typedef struct packed {
    logic full;
  } vzz_qstat_t;

endpackage
`default_nettype wire

/* hw/rtl/vzz_item_if.sv */
// Interface: input channel of the codec (valid/ready plus item fields).
`default_nettype none
interface vzz_item_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic        is_signed;
  logic        is_wide;
  logic [63:0] value_in;
  logic [7:0]  byte_in;

  modport source (output valid, opcode, is_signed, is_wide, value_in, byte_in,
                  input ready);
  modport sink   (input valid, opcode, is_signed, is_wide, value_in, byte_in,
                  output ready);
endinterface
`default_nettype wire

/* hw/rtl/vzz_result_if.sv */
// Interface: result channel of the codec (valid/ready plus result fields).
`default_nettype none
interface vzz_result_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  byte_out;
  logic [63:0] value_out;
  logic        last;

  modport source (output valid, out_kind, byte_out, value_out, last,
                  input ready);
  modport sink   (input valid, out_kind, byte_out, value_out, last,
                  output ready);
endinterface
`default_nettype wire

/* hw/rtl/varint_zigzag_codec.sv */
// Top level: base-128 varint codec with zigzag mapping, 32- and 64-bit forms.
// A result passes the job queue, the back end's job register and its output register.
// Throughput: one input transaction per cycle while the job queue has room;
// the back end emits one result per cycle while result.ready allows (one per byte).
// Reset clears the queue, the decode run state and the output valid; no clearing pass.
`default_nettype none
module varint_zigzag_codec #(
  parameter int unsigned QueueDepth = vzz_pkg::QUEUE_DEPTH
) (
  input  wire          clk,
  input  wire          rst,
  vzz_item_if.sink     item,
  vzz_result_if.source result
);

  vzz_pkg::vzz_job_t   push_job;
  vzz_pkg::vzz_job_t   head_job;
  vzz_pkg::vzz_qstat_t qstat;
  logic                push;
  logic                pop;
  logic                empty;

  vzz_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .qstat    (qstat),
    .push     (push),
    .push_job (push_job)
  );

  vzz_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .stat     (qstat),
    .pop      (pop),
    .head_job (head_job),
    .empty    (empty)
  );

  vzz_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_job (head_job),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
`default_nettype wire

/* hw/rtl/vzz_queue.sv */
// Module: small register FIFO of jobs between the front and back end.
`default_nettype none
module vzz_queue #(
  parameter int unsigned Depth = vzz_pkg::QUEUE_DEPTH
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  vzz_pkg::vzz_job_t      push_job,
  output vzz_pkg::vzz_qstat_t    stat,
  input  wire                    pop,
  output vzz_pkg::vzz_job_t      head_job,
  output logic                   empty
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  vzz_pkg::vzz_job_t mem [Depth];
  logic [PtrW-1:0] head;
  logic [PtrW-1:0] tail;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign stat.full = (count == FullCnt);
  assign empty     = (count == '0);
  assign head_job  = mem[head];
  assign do_push   = push && !stat.full;
  assign do_pop    = pop && !empty;

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == LastPtr) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (head == LastPtr) ? '0 : head + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/vzz_front.sv */
// Module: front end; accepts transactions, zigzag-maps encodes, accumulates decodes.
`default_nettype none
module vzz_front (
  input  wire                   clk,
  input  wire                   rst,
  vzz_item_if.sink              item,
  input  vzz_pkg::vzz_qstat_t   qstat,
  output logic                  push,
  output vzz_pkg::vzz_job_t     push_job
);

  // Decode run state
  logic [63:0] acc;
  logic [3:0]  count;
  logic [5:0]  shamt;
  logic        sgn_l;
  logic        wide_l;

  logic        accept;
  logic        first;
  logic        cur_wide;
  logic        cur_sgn;
  logic [5:0]  cur_shamt;
  logic [63:0] mask;
  logic [63:0] contrib;
  logic [63:0] acc_next;
  logic [3:0]  count_next;
  logic [3:0]  max_bytes;
  logic        done;
  logic [63:0] enc_value;
  logic [31:0] narrow_w;

  assign item.ready = !qstat.full;
  assign accept     = item.valid && item.ready;

  // Decode step: place seven payload bits at the current position
  always_comb begin
    first      = (count == 4'd0);
    cur_wide   = first ? item.is_wide   : wide_l;
    cur_sgn    = first ? item.is_signed : sgn_l;
    cur_shamt  = first ? 6'd0 : shamt;
    mask       = cur_wide ? {64{1'b1}} : {32'd0, {32{1'b1}}};
    contrib    = ({57'd0, item.byte_in[6:0] & vzz_pkg::PAYLOAD_MASK} << cur_shamt) & mask;
    acc_next   = (first ? 64'd0 : acc) | contrib;
    count_next = count + 4'd1;
    max_bytes  = cur_wide ? vzz_pkg::WIDE_MAX_BYTES : vzz_pkg::NARROW_MAX_BYTES;
    done       = ((item.byte_in & vzz_pkg::CONT_BIT) == 8'd0) || (count_next == max_bytes);
  end

  // Encode mapping: zigzag when signed, narrow form uses low 32 bits
  always_comb begin
    narrow_w = item.value_in[31:0];
    if (item.is_signed) begin
      narrow_w = {item.value_in[30:0], 1'b0} ^ {32{item.value_in[31]}};
    end
    if (item.is_wide) begin
      enc_value = item.value_in;
      if (item.is_signed) begin
        enc_value = {item.value_in[62:0], 1'b0} ^ {64{item.value_in[63]}};
      end
    end else begin
      enc_value = {32'd0, narrow_w};
    end
  end

  // Job to the queue
  always_comb begin
    push               = 1'b0;
    push_job.kind      = vzz_pkg::KIND_BYTE;
    push_job.is_signed = 1'b0;
    push_job.is_wide   = 1'b0;
    push_job.value     = enc_value;
    if (accept) begin
      if (item.opcode == vzz_pkg::OP_ENCODE) begin
        push = 1'b1;
      end else if (done) begin
        push               = 1'b1;
        push_job.kind      = vzz_pkg::KIND_VALUE;
        push_job.is_signed = cur_sgn;
        push_job.is_wide   = cur_wide;
        push_job.value     = acc_next;
      end
    end
  end

  // Decode run state update; encodes leave it alone
  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      count  <= '0;
      shamt  <= '0;
      sgn_l  <= 1'b0;
      wide_l <= 1'b0;
    end else if (accept && item.opcode == vzz_pkg::OP_DECODE) begin
      if (done) begin
        acc    <= '0;
        count  <= '0;
        shamt  <= '0;
        sgn_l  <= 1'b0;
        wide_l <= 1'b0;
      end else begin
        acc    <= acc_next;
        count  <= count_next;
        shamt  <= cur_shamt + 6'(vzz_pkg::PAYLOAD_BITS);
        sgn_l  <= cur_sgn;
        wide_l <= cur_wide;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/vzz_back.sv */
// Module: back end; serializes encode jobs into bytes, emits decoded values.
`default_nettype none
module vzz_back (
  input  wire                   clk,
  input  wire                   rst,
  input  vzz_pkg::vzz_job_t     head_job,
  input  wire                   empty,
  output logic                  pop,
  vzz_result_if.source          result
);

  // Job in progress
  logic        busy;
  logic        kind;
  logic        sgn;
  logic        wide;
  logic [63:0] work;

  logic        advance;
  logic        finish;
  logic        is_final_byte;
  logic [7:0]  byte_next;
  logic [63:0] value_next;
  logic [31:0] narrow_dec;

  assign advance       = busy && (!result.valid || result.ready);
  assign is_final_byte = (work[63:7] == 57'd0);
  assign finish        = advance && (kind == vzz_pkg::KIND_VALUE || is_final_byte);
  assign pop           = !empty && (!busy || finish);

  // Result of the current step
  always_comb begin
    byte_next  = {1'b0, work[6:0] & vzz_pkg::PAYLOAD_MASK};
    if (!is_final_byte) begin
      byte_next = byte_next | vzz_pkg::CONT_BIT;
    end
    narrow_dec = {1'b0, work[31:1]} ^ {32{work[0]}};
    if (!sgn) begin
      value_next = work;
    end else if (wide) begin
      value_next = {1'b0, work[63:1]} ^ {64{work[0]}};
    end else begin
      value_next = {{32{narrow_dec[31]}}, narrow_dec};
    end
  end

  // Job register and byte shifter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
    end else if (finish) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind <= head_job.kind;
      sgn  <= head_job.is_signed;
      wide <= head_job.is_wide;
      work <= head_job.value;
    end else if (advance) begin
      work <= work >> vzz_pkg::PAYLOAD_BITS;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.out_kind <= kind;
      if (kind == vzz_pkg::KIND_VALUE) begin
        result.byte_out  <= 8'd0;
        result.value_out <= value_next;
        result.last      <= 1'b1;
      end else begin
        result.byte_out  <= byte_next;
        result.value_out <= 64'd0;
        result.last      <= is_final_byte;
      end
    end
  end

endmodule
`default_nettype wire
